[rtl/toroidal_bitmap_overlap_stamp_top_assert.svh]
// assertion macros for the toroidal bitmap overlap stamp
`ifndef TOROIDAL_BITMAP_OVERLAP_STAMP_TOP_ASSERT_SVH
`define TOROIDAL_BITMAP_OVERLAP_STAMP_TOP_ASSERT_SVH

// same-cycle implication, off while in reset
`define TBOS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off while in reset
`define TBOS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/tbos_pkg.sv]
// shared constants, types and helpers for the toroidal bitmap overlap stamp
package tbos_pkg;

  localparam int unsigned CANVAS_W_DEFAULT = 256;
  localparam int unsigned CANVAS_H_DEFAULT = 256;
  localparam int unsigned MAX_IMAGE_W      = 64;

  localparam int unsigned DIM_W      = 9;
  localparam int unsigned POS_W      = 8;
  localparam int unsigned ROW_IDX_W  = 6;
  localparam int unsigned IMG_W_W    = 7;
  localparam int unsigned ROW_BITS_W = 64;
  localparam int unsigned COUNT_W    = 13;
  localparam int unsigned LEN_W      = 7;
  localparam int unsigned OFF_W      = 6;
  localparam int unsigned NIDX_W     = 2 * DIM_W;
  localparam int unsigned STEP_CNT_W = $clog2(DIM_W);
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 3;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [DIM_W-1:0]   DIM_RESET = DIM_W'(256);

  typedef enum logic {
    REG_CANVAS_WIDTH  = 1'b0,
    REG_CANVAS_HEIGHT = 1'b1
  } reg_idx_e;

  typedef enum logic {
    MODE_QUERY = 1'b0,
    MODE_STAMP = 1'b1
  } mode_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MOD,
    ST_READ,
    ST_WRITE,
    ST_DONE
  } state_e;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input int unsigned maxv);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (32'(v) > maxv) begin
      r = DIM_W'(maxv);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

[rtl/tbos_mod.sv]
// iterative remainder unit, one quotient bit per cycle with a fast path
module tbos_mod
  import tbos_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DIM_W-1:0] num_i,
  input  logic [DIM_W-1:0] den_i,
  output logic             busy_o,
  output logic [DIM_W-1:0] rem_o
);

  logic                  busy_q;
  logic [STEP_CNT_W-1:0] cnt_q;
  logic [DIM_W-1:0]      num_q;
  logic [DIM_W-1:0]      den_q;
  logic [DIM_W-1:0]      rem_q;
  logic [DIM_W:0]        shifted;
  logic [DIM_W:0]        diff;
  logic                  fits;

  assign shifted = {rem_q, num_q[DIM_W-1]};
  assign diff    = shifted - {1'b0, den_q};
  assign fits    = (shifted >= {1'b0, den_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= (num_i >= den_i);
      cnt_q  <= STEP_CNT_W'(DIM_W - 1);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= (num_i < den_i) ? num_i : '0;
    end else if (busy_q) begin
      num_q <= num_q << 1;
      rem_q <= fits ? diff[DIM_W-1:0] : shifted[DIM_W-1:0];
    end
  end

  assign busy_o = busy_q;
  assign rem_o  = rem_q;

endmodule

[rtl/tbos_ram.sv]
// single-port canvas word memory with registered read data
module tbos_ram
  import tbos_pkg::*;
#(
  parameter int unsigned DEPTH  = 1024,
  parameter int unsigned ADDR_W = 10
) (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic                  we_i,
  input  logic [ADDR_W-1:0]     addr_i,
  input  logic [ROW_BITS_W-1:0] wdata_i,
  output logic [ROW_BITS_W-1:0] rdata_o
);

  logic [ROW_BITS_W-1:0] mem_q [DEPTH];
  logic [ROW_BITS_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/toroidal_bitmap_overlap_stamp_top.sv]
// toroidal bitmap overlap stamp: apb registers, row sequencer and canvas memory
// a row is split into 0 to 64 word pieces; each piece is a read, then in stamp mode a write-back
// a new row is taken only in the idle state, once the previous row is finished
// the position wrap runs the remainder steps only when pos_x reaches the width or pos_y + row_index the height
// a finished result waits in the output register and holds the next last row while stalled
// after reset a clearing pass zeroes every canvas word before the first transfer
`include "toroidal_bitmap_overlap_stamp_top_assert.svh"

module toroidal_bitmap_overlap_stamp_top
  import tbos_pkg::*;
#(
  parameter int unsigned MAX_CANVAS_W = CANVAS_W_DEFAULT,
  parameter int unsigned MAX_CANVAS_H = CANVAS_H_DEFAULT
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,

  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,

  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  mode_i,
  input  logic [POS_W-1:0]      pos_x_i,
  input  logic [POS_W-1:0]      pos_y_i,
  input  logic [ROW_IDX_W-1:0]  row_index_i,
  input  logic [IMG_W_W-1:0]    image_width_i,
  input  logic [ROW_BITS_W-1:0] row_bits_i,
  input  logic                  last_row_i,

  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [COUNT_W-1:0]    overlap_count_o,
  output logic                  was_stamp_o
);

  localparam int unsigned CanvasWords = (MAX_CANVAS_W * MAX_CANVAS_H + 63) / 64;
  localparam int unsigned AddrW       = (CanvasWords > 1) ? $clog2(CanvasWords) : 1;
  localparam logic [AddrW-1:0] LastAddr = AddrW'(CanvasWords - 1);

  logic [DIM_W-1:0] cfg_w_q;
  logic [DIM_W-1:0] cfg_h_q;
  logic [DIM_W-1:0] w_eff;
  logic [DIM_W-1:0] h_eff;
  logic             apb_wr;

  state_e state_q, state_d;

  mode_e                 mode_q;
  logic                  last_q;
  logic [ROW_BITS_W-1:0] bits_q;
  logic [IMG_W_W-1:0]    left_q;
  logic [DIM_W-1:0]      x_q;
  logic [NIDX_W-1:0]     n_q;
  logic [NIDX_W-1:0]     row_base_q;
  logic [LEN_W-1:0]      len_q;
  logic [ROW_BITS_W-1:0] mask_q;
  logic [AddrW-1:0]      addr_q;
  logic [COUNT_W-1:0]    count_q;
  logic [AddrW-1:0]      clr_q;
  logic                  out_valid_q;
  logic [COUNT_W-1:0]    out_count_q;
  logic                  out_stamp_q;

  logic                  accept;
  logic                  mods_done;
  logic                  out_free;
  logic                  load_out;
  logic                  piece_last;

  logic                  ymod_busy;
  logic                  xmod_busy;
  logic [DIM_W-1:0]      ymod_rem;
  logic [DIM_W-1:0]      xmod_rem;
  logic [DIM_W-1:0]      y_num;

  logic [OFF_W-1:0]      off;
  logic [DIM_W-1:0]      rem_w;
  logic [LEN_W-1:0]      rem_word;
  logic [LEN_W-1:0]      len_min;
  logic [LEN_W-1:0]      len_c;
  logic [ROW_BITS_W-1:0] low_mask;
  logic [ROW_BITS_W-1:0] mask_c;
  logic [AddrW-1:0]      addr_c;
  logic [LEN_W-1:0]      pop;
  logic [COUNT_W:0]      sum;
  logic [COUNT_W-1:0]    count_sat;
  logic [DIM_W-1:0]      x_next;
  logic [IMG_W_W-1:0]    iw_clamped;

  logic                  ram_en;
  logic                  ram_we;
  logic [AddrW-1:0]      ram_addr;
  logic [ROW_BITS_W-1:0] ram_wdata;
  logic [ROW_BITS_W-1:0] ram_rdata;

  // configuration registers
  assign apb_wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_w_q <= DIM_RESET;
      cfg_h_q <= DIM_RESET;
    end else if (apb_wr) begin
      unique case (reg_idx_e'(paddr[2]))
        REG_CANVAS_WIDTH:  cfg_w_q <= pwdata[DIM_W-1:0];
        REG_CANVAS_HEIGHT: cfg_h_q <= pwdata[DIM_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_e'(paddr[2]))
      REG_CANVAS_WIDTH:  prdata = APB_DATA_W'(cfg_w_q);
      REG_CANVAS_HEIGHT: prdata = APB_DATA_W'(cfg_h_q);
    endcase
  end

  assign w_eff = clamp_dim(cfg_w_q, MAX_CANVAS_W);
  assign h_eff = clamp_dim(cfg_h_q, MAX_CANVAS_H);

  // position wrap
  assign y_num = DIM_W'(pos_y_i) + DIM_W'(row_index_i);

  tbos_mod u_ymod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept),
    .num_i   (y_num),
    .den_i   (h_eff),
    .busy_o  (ymod_busy),
    .rem_o   (ymod_rem)
  );

  tbos_mod u_xmod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept),
    .num_i   (DIM_W'(pos_x_i)),
    .den_i   (w_eff),
    .busy_o  (xmod_busy),
    .rem_o   (xmod_rem)
  );

  // piece datapath
  assign accept     = in_valid_i && !in_stall_o;
  assign mods_done  = !ymod_busy && !xmod_busy;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign piece_last = (left_q == len_q);
  assign iw_clamped = (32'(image_width_i) > MAX_IMAGE_W) ? IMG_W_W'(MAX_IMAGE_W)
                                                         : image_width_i;

  assign off      = n_q[OFF_W-1:0];
  assign rem_w    = w_eff - x_q;
  assign rem_word = LEN_W'(64) - LEN_W'(off);
  assign len_min  = (left_q < rem_word) ? left_q : rem_word;
  assign len_c    = (rem_w < DIM_W'(len_min)) ? LEN_W'(rem_w) : len_min;
  assign low_mask = ~({ROW_BITS_W{1'b1}} << len_c);
  assign mask_c   = (bits_q & low_mask) << off;
  assign addr_c   = AddrW'(n_q >> OFF_W);

  assign pop       = LEN_W'($countones(ram_rdata & mask_q));
  assign sum       = {1'b0, count_q} + (COUNT_W + 1)'(pop);
  assign count_sat = sum[COUNT_W] ? COUNT_MAX : sum[COUNT_W-1:0];
  assign x_next    = x_q + DIM_W'(len_q);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: if (clr_q == LastAddr) state_d = ST_IDLE;
      ST_IDLE:  if (in_valid_i) state_d = ST_MOD;
      ST_MOD: begin
        if (mods_done) begin
          state_d = (left_q == '0) ? ST_DONE : ST_READ;
        end
      end
      ST_READ:  state_d = ST_WRITE;
      ST_WRITE: state_d = piece_last ? ST_DONE : ST_READ;
      ST_DONE:  if (!last_q || out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_stall_o = 1'b1;
    ram_en     = 1'b0;
    ram_we     = 1'b0;
    ram_addr   = addr_q;
    ram_wdata  = ram_rdata | mask_q;
    load_out   = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        ram_en    = 1'b1;
        ram_we    = 1'b1;
        ram_addr  = clr_q;
        ram_wdata = '0;
      end
      ST_IDLE: in_stall_o = 1'b0;
      ST_READ: begin
        ram_en   = 1'b1;
        ram_addr = addr_c;
      end
      ST_WRITE: begin
        ram_en = (mode_q == MODE_STAMP);
        ram_we = (mode_q == MODE_STAMP);
      end
      ST_DONE: load_out = last_q && out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) begin
        clr_q <= clr_q + 1'b1;
      end
      if (load_out) begin
        count_q <= '0;
      end else if (state_q == ST_WRITE && mode_q == MODE_QUERY) begin
        count_q <= count_sat;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q <= mode_e'(mode_i);
      last_q <= last_row_i;
      bits_q <= row_bits_i;
      left_q <= iw_clamped;
    end
    if (state_q == ST_MOD && mods_done) begin
      row_base_q <= NIDX_W'(ymod_rem) * NIDX_W'(w_eff);
      n_q        <= NIDX_W'(ymod_rem) * NIDX_W'(w_eff) + NIDX_W'(xmod_rem);
      x_q        <= xmod_rem;
    end
    if (state_q == ST_READ) begin
      len_q  <= len_c;
      mask_q <= mask_c;
      addr_q <= addr_c;
    end
    if (state_q == ST_WRITE) begin
      bits_q <= bits_q >> len_q;
      left_q <= left_q - len_q;
      if (x_next == w_eff) begin
        x_q <= '0;
        n_q <= row_base_q;
      end else begin
        x_q <= x_next;
        n_q <= n_q + NIDX_W'(len_q);
      end
    end
    if (load_out) begin
      out_count_q <= (mode_q == MODE_STAMP) ? '0 : count_q;
      out_stamp_q <= (mode_q == MODE_STAMP);
    end
  end

  tbos_ram #(
    .DEPTH  (CanvasWords),
    .ADDR_W (AddrW)
  ) u_ram (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o     = out_valid_q;
  assign overlap_count_o = out_count_q;
  assign was_stamp_o     = out_stamp_q;

  `TBOS_ASSERT_NXT(a_accept_starts_wrap, in_valid_i && !in_stall_o, state_q == ST_MOD, "accepted transfer did not enter the wrap step")
  `TBOS_ASSERT_IMP(a_write_phase, ram_we, state_q == ST_CLEAR || (state_q == ST_WRITE && mode_q == MODE_STAMP), "canvas written outside clear or stamp write")
  `TBOS_ASSERT_IMP(a_piece_nonempty, state_q == ST_READ, len_c != '0, "empty canvas piece would stall the row")
  `TBOS_ASSERT_IMP(a_stamp_zero_count, out_valid_o && was_stamp_o, overlap_count_o == '0, "stamp result carries a nonzero count")

endmodule
